// ===== rtl/sha1md_pkg.sv =====
// shared constants, command and status types for the sha-1 digest unit
package sha1md_pkg;

   localparam logic [31:0] K0 = 32'h5A827999;
   localparam logic [31:0] K1 = 32'h6ED9EBA1;
   localparam logic [31:0] K2 = 32'h8F1BBCDC;
   localparam logic [31:0] K3 = 32'hCA62C1D6;

   localparam logic [31:0] H0_INIT = 32'h67452301;
   localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
   localparam logic [31:0] H2_INIT = 32'h98BADCFE;
   localparam logic [31:0] H3_INIT = 32'h10325476;
   localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

   localparam logic [7:0] PAD_MARK = 8'h80;

   localparam int unsigned ROUNDS = 80;
   localparam logic [6:0] LAST_ROUND = 7'(ROUNDS - 1);
   localparam logic [5:0] LAST_POS = 6'd63;
   localparam logic [5:0] LEN_POS = 6'd56;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_ROUND  = 5'b00010,
      ST_UPDATE = 5'b00100,
      ST_PAD    = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   typedef struct packed {
      logic shift_byte;
      logic shift_pad;
      logic round_en;
      logic update;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic pos_last;
      logic pad_is_len;
      logic round_last;
      logic out_free;
   } status_type;

endpackage

// ===== rtl/sha1md_ctrl.sv =====
// sequencing state machine for the sha-1 digest unit
module sha1md_ctrl
   import sha1md_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic       req_tlast,
   input  logic       req_tuser,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic after_pad_ff, after_pad_in;
   logic after_fin_ff, after_fin_in;
   logic accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      after_pad_in = after_pad_ff;
      after_fin_in = after_fin_ff;
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.shift_byte = req_tuser;
               if (req_tuser && status.pos_last) begin
                  state_in = ST_ROUND;
                  after_pad_in = req_tlast;
                  after_fin_in = 1'b0;
               end else if (req_tlast) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_ROUND: begin
            cmd.round_en = 1'b1;
            if (status.round_last) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            if (after_fin_ff) begin
               state_in = ST_FINISH;
            end else if (after_pad_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_PAD: begin
            cmd.shift_pad = 1'b1;
            if (status.pos_last) begin
               state_in = ST_ROUND;
               after_pad_in = !status.pad_is_len;
               after_fin_in = status.pad_is_len;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         after_pad_ff <= 1'b0;
         after_fin_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         after_pad_ff <= after_pad_in;
         after_fin_ff <= after_fin_in;
      end
   end

endmodule

// ===== rtl/sha1md_dp.sv =====
// block buffer, message schedule, round logic, chaining values and digest register
module sha1md_dp
   import sha1md_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic [7:0]   req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [159:0] rsp_tdata,
   input  cmd_type      cmd,
   output status_type   status
);

   logic [511:0] msg_ff, msg_in;
   logic [31:0]  a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0]  a_in, b_in, c_in, d_in, e_in;
   logic [31:0]  h0_ff, h1_ff, h2_ff, h3_ff, h4_ff;
   logic [31:0]  h0_in, h1_in, h2_in, h3_in, h4_in;
   logic [63:0]  bit_count_ff, bit_count_in;
   logic [5:0]   pos_ff, pos_in;
   logic [6:0]   rnd_ff, rnd_in;
   logic         mark_sent_ff, mark_sent_in;
   logic         two_block_ff, two_block_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [159:0] digest_ff, digest_in;

   logic [31:0] w0, w2, w8, w13, sched_mix, sched_new;
   logic [31:0] f, k, tmp;
   logic [7:0]  pad_byte, len_byte;
   logic [2:0]  len_idx;
   logic [63:0] len_shift;
   logic        is_len;

   assign w0  = msg_ff[511:480];
   assign w2  = msg_ff[447:416];
   assign w8  = msg_ff[255:224];
   assign w13 = msg_ff[95:64];
   assign sched_mix = w13 ^ w8 ^ w2 ^ w0;
   assign sched_new = {sched_mix[30:0], sched_mix[31]};

   always_comb begin
      if (rnd_ff < 7'd20) begin
         f = (b_ff & c_ff) | (~b_ff & d_ff);
         k = K0;
      end else if (rnd_ff < 7'd40) begin
         f = b_ff ^ c_ff ^ d_ff;
         k = K1;
      end else if (rnd_ff < 7'd60) begin
         f = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         k = K2;
      end else begin
         f = b_ff ^ c_ff ^ d_ff;
         k = K3;
      end
   end

   assign tmp = {a_ff[26:0], a_ff[31:27]} + f + e_ff + k + w0;

   // big-endian length, byte 56 carries the top bits
   assign len_idx = 3'd7 - pos_ff[2:0];
   assign len_shift = bit_count_ff >> {len_idx, 3'b000};
   assign len_byte = len_shift[7:0];
   assign is_len = mark_sent_ff && (pos_ff >= LEN_POS) && !two_block_ff;

   always_comb begin
      if (!mark_sent_ff) begin
         pad_byte = PAD_MARK;
      end else if (is_len) begin
         pad_byte = len_byte;
      end else begin
         pad_byte = 8'h00;
      end
   end

   assign status.pos_last = (pos_ff == LAST_POS);
   assign status.pad_is_len = is_len;
   assign status.round_last = (rnd_ff == LAST_ROUND);
   assign status.out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      msg_in = msg_ff;
      pos_in = pos_ff;
      bit_count_in = bit_count_ff;
      mark_sent_in = mark_sent_ff;
      two_block_in = two_block_ff;
      if (cmd.shift_byte) begin
         msg_in = {msg_ff[503:0], req_tdata};
         pos_in = pos_ff + 6'd1;
         bit_count_in = bit_count_ff + 64'd8;
      end else if (cmd.shift_pad) begin
         msg_in = {msg_ff[503:0], pad_byte};
         pos_in = pos_ff + 6'd1;
         mark_sent_in = 1'b1;
         if (!mark_sent_ff && (pos_ff >= LEN_POS)) begin
            two_block_in = 1'b1;
         end
      end else if (cmd.round_en) begin
         msg_in = {msg_ff[479:0], sched_new};
      end
      if (cmd.update) begin
         two_block_in = 1'b0;
      end
      if (cmd.finish) begin
         pos_in = '0;
         bit_count_in = '0;
         mark_sent_in = 1'b0;
         two_block_in = 1'b0;
      end
   end

   // working variables follow the chain whenever no round runs
   always_comb begin
      if (cmd.round_en) begin
         a_in = tmp;
         b_in = a_ff;
         c_in = {b_ff[1:0], b_ff[31:2]};
         d_in = c_ff;
         e_in = d_ff;
         rnd_in = rnd_ff + 7'd1;
      end else begin
         a_in = h0_ff;
         b_in = h1_ff;
         c_in = h2_ff;
         d_in = h3_ff;
         e_in = h4_ff;
         rnd_in = '0;
      end
   end

   always_comb begin
      h0_in = h0_ff;
      h1_in = h1_ff;
      h2_in = h2_ff;
      h3_in = h3_ff;
      h4_in = h4_ff;
      digest_in = digest_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (cmd.update) begin
         h0_in = h0_ff + a_ff;
         h1_in = h1_ff + b_ff;
         h2_in = h2_ff + c_ff;
         h3_in = h3_ff + d_ff;
         h4_in = h4_ff + e_ff;
      end
      if (cmd.finish) begin
         digest_in = {h4_ff, h3_ff, h2_ff, h1_ff, h0_ff};
         rsp_valid_in = 1'b1;
         h0_in = H0_INIT;
         h1_in = H1_INIT;
         h2_in = H2_INIT;
         h3_in = H3_INIT;
         h4_in = H4_INIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h0_ff <= H0_INIT;
         h1_ff <= H1_INIT;
         h2_ff <= H2_INIT;
         h3_ff <= H3_INIT;
         h4_ff <= H4_INIT;
         bit_count_ff <= '0;
         pos_ff <= '0;
         rnd_ff <= '0;
         mark_sent_ff <= 1'b0;
         two_block_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         h0_ff <= h0_in;
         h1_ff <= h1_in;
         h2_ff <= h2_in;
         h3_ff <= h3_in;
         h4_ff <= h4_in;
         bit_count_ff <= bit_count_in;
         pos_ff <= pos_in;
         rnd_ff <= rnd_in;
         mark_sent_ff <= mark_sent_in;
         two_block_ff <= two_block_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      msg_ff <= msg_in;
      a_ff <= a_in;
      b_ff <= b_in;
      c_ff <= c_in;
      d_ff <= d_in;
      e_ff <= e_in;
      digest_ff <= digest_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = digest_ff;

endmodule

// ===== rtl/sha1_message_digest_unit.sv =====
// top level of the sha-1 digest unit: controller and datapath
// Takes one message byte per beat and returns the SHA-1 digest of each message after the beat
// marked with tlast. Each 64th byte of a message starts the 80 rounds of the compression and
// the chaining update, during which req_tready is low. The end of a message adds the padding
// bytes (up to 64, or up to 72 when the length spills into a second block), the rounds and
// chaining update for each padded block, and the load of the digest register.
// The digest sits in an output register, so the next message is accepted while it waits;
// only a second digest finishing before the first is taken stalls the unit.
module sha1_message_digest_unit
   import sha1md_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,  // message_byte
   input  logic         req_tuser,  // byte_present
   input  logic         req_tlast,  // end_of_message
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [159:0] rsp_tdata   // digest_h0, digest_h1, digest_h2, digest_h3, digest_h4
);

   cmd_type    cmd;
   status_type status;

   sha1md_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   sha1md_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

// ===== dv/testbench.sv =====
// self-checking testbench for the sha-1 digest unit: predicted digests against streamed results
module testbench;
   import sha1md_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [31:0] word_type;
   typedef logic [4:0][31:0] digest_type;

   localparam int unsigned ITEM_TARGET = 1350;
   localparam int unsigned MIN_MESSAGES = 40;
   localparam int unsigned IDLE_PCT = 13;
   localparam int unsigned NOISE_PCT = 4;
   localparam int unsigned HOLD_CYCLES = 400;
   localparam int unsigned DRAIN_CYCLES = 400;
   localparam int unsigned STALL_LIMIT = 5000;
   localparam int unsigned PRINT_LIMIT = 40;
   localparam int unsigned PAD_EDGE_LENGTHS [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

   logic clock = 1'b0;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [7:0] req_tdata;
   logic req_tuser;
   logic req_tlast;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [159:0] rsp_tdata;

   logic steady;
   logic hold_request;
   int unsigned hold_left = 0;
   bit hold_taken = 1'b0;
   int unsigned quiet_cycles = 0;

   word_type chain_words [5];
   logic [63:0] message_bits;
   logic [7:0] block_bytes [64];
   digest_type digests_due [$];

   int unsigned mismatches = 0;
   int unsigned beats_sent = 0;
   int unsigned messages_sent = 0;
   int unsigned digests_checked = 0;

   sha1_message_digest_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #4 clock = ~clock;

   function automatic word_type rol(input word_type x, input int unsigned n);
      return (x << n) | (x >> (32 - n));
   endfunction

   function automatic void sha1_restart();
      chain_words = '{H0_INIT, H1_INIT, H2_INIT, H3_INIT, H4_INIT};
      message_bits = '0;
   endfunction

   function automatic void sha1_compress();
      word_type w [80];
      word_type a, b, c, d, e, f, k, t;
      for (int i = 0; i < 16; i++)
         w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
      for (int i = 16; i < 80; i++)
         w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
      a = chain_words[0];
      b = chain_words[1];
      c = chain_words[2];
      d = chain_words[3];
      e = chain_words[4];
      for (int i = 0; i < ROUNDS; i++) begin
         if (i < 20) begin
            f = (b & c) | (~b & d);
            k = K0;
         end else if (i < 40) begin
            f = b ^ c ^ d;
            k = K1;
         end else if (i < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = K2;
         end else begin
            f = b ^ c ^ d;
            k = K3;
         end
         t = rol(a, 5) + f + e + k + w[i];
         e = d;
         d = c;
         c = rol(b, 30);
         b = a;
         a = t;
      end
      chain_words[0] += a;
      chain_words[1] += b;
      chain_words[2] += c;
      chain_words[3] += d;
      chain_words[4] += e;
   endfunction

   // one accepted beat into the running hash; finishes the message on its end flag
   function automatic void sha1_absorb(input logic [7:0] data, input logic present,
                                       input logic last, output bit done, output digest_type dig);
      int unsigned pos;
      logic [63:0] length;
      done = 1'b0;
      dig = '0;
      if (present) begin
         pos = 32'(message_bits[8:3]);
         block_bytes[pos] = data;
         message_bits += 64'd8;
         if (pos == LAST_POS)
            sha1_compress();
      end
      if (last) begin
         length = message_bits;
         pos = 32'(message_bits[8:3]);
         block_bytes[pos] = PAD_MARK;
         if (pos >= LEN_POS) begin
            for (int i = pos + 1; i < 64; i++)
               block_bytes[i] = 8'h00;
            sha1_compress();
            for (int i = 0; i < LEN_POS; i++)
               block_bytes[i] = 8'h00;
         end else begin
            for (int i = pos + 1; i < LEN_POS; i++)
               block_bytes[i] = 8'h00;
         end
         for (int i = 0; i < 8; i++)
            block_bytes[LEN_POS + i] = length[63 - 8*i -: 8];
         sha1_compress();
         for (int i = 0; i < 5; i++)
            dig[i] = chain_words[i];
         done = 1'b1;
         sha1_restart();
      end
   endfunction

   task automatic report_mismatch(input string what);
      if (mismatches < PRINT_LIMIT)
         $display("%0t mismatch: %s", $realtime, what);
      mismatches++;
   endtask

   task automatic send_beat(input logic [7:0] data, input logic present, input logic last);
      bit done;
      digest_type dig;
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= data;
      req_tuser <= present;
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      sha1_absorb(data, present, last, done, dig);
      if (done) begin
         digests_due.push_back(dig);
         messages_sent++;
      end
      beats_sent++;
   endtask

   // len random bytes; the end flag rides on the last byte or on an empty beat after it
   task automatic send_message(input int unsigned len, input bit end_on_byte,
                               input int unsigned noise_pct);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(99) < noise_pct)
            send_beat(8'($urandom_range(255)), 1'b0, 1'b0);
         send_beat(8'($urandom_range(255)), 1'b1, end_on_byte && (i == len - 1));
      end
      if (!end_on_byte || len == 0)
         send_beat(8'($urandom_range(255)), 1'b0, 1'b1);
   endtask

   task automatic test_empty_message();
      send_beat(8'h00, 1'b0, 1'b1);
      send_beat(8'hFF, 1'b0, 1'b0);
      send_beat(8'hA5, 1'b0, 1'b1);
   endtask

   task automatic test_short_messages();
      send_beat(8'h61, 1'b1, 1'b0);
      send_beat(8'h62, 1'b1, 1'b0);
      send_beat(8'h63, 1'b1, 1'b1);
      send_beat(8'hFF, 1'b1, 1'b0);
      send_beat(8'h00, 1'b0, 1'b0);
      send_beat(8'h5A, 1'b0, 1'b1);
      send_beat(8'h00, 1'b1, 1'b1);
      send_beat(8'hFF, 1'b1, 1'b1);
   endtask

   // result side held off long enough for a second digest to back up into the input
   task automatic test_output_backpressure();
      hold_request <= 1'b1;
      for (int i = 0; i < 6; i++)
         send_message($urandom_range(3), 1'($urandom_range(1)), 0);
   endtask

   task automatic test_random_messages();
      int unsigned len;
      int unsigned roll;
      int unsigned msg;
      msg = 0;
      while (beats_sent < ITEM_TARGET || msg < MIN_MESSAGES) begin
         steady <= (msg >= 12 && msg < 22);
         roll = $urandom_range(99);
         if (roll < 20)
            len = PAD_EDGE_LENGTHS[$urandom_range(9)];
         else if (roll < 23)
            len = $urandom_range(300, 150);
         else
            len = $urandom_range(24);
         send_message(len, 1'($urandom_range(1)), NOISE_PCT);
         msg++;
      end
      steady <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_request && !hold_taken) begin
         rsp_tready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_taken <= 1'b1;
      end else begin
         rsp_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   always @(posedge clock) begin
      digest_type got;
      digest_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (digests_due.size() == 0) begin
            report_mismatch($sformatf("digest %h with none outstanding", got));
         end else begin
            want = digests_due.pop_front();
            for (int i = 0; i < 5; i++)
               if (got[i] !== want[i])
                  report_mismatch($sformatf("message %0d h%0d got %h want %h",
                                            digests_checked, i, got[i], want[i]));
            digests_checked++;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
         $display("%0t watchdog: no beat for %0d cycles", $realtime, STALL_LIMIT);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= 8'h00;
      req_tuser <= 1'b0;
      req_tlast <= 1'b0;
      steady <= 1'b0;
      hold_request <= 1'b0;
      sha1_restart();
      for (int i = 0; i < 64; i++)
         block_bytes[i] = 8'h00;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_empty_message();
      test_short_messages();
      test_output_backpressure();
      test_random_messages();
      req_tvalid <= 1'b0;
      while (digests_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d input beats over %0d messages, %0d digests compared",
               beats_sent, messages_sent, digests_checked);
      $display("empty and one-byte messages, padding edges, long messages, output hold-off");
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/sha1md_pkg.sv
rtl/sha1md_ctrl.sv
rtl/sha1md_dp.sv
rtl/sha1_message_digest_unit.sv
dv/testbench.sv
